// File: rtl/sbe_pkg.sv
// Shared types, codes and helper functions of the sparse bitset engine.
`timescale 1ns / 1ps

package sbe_pkg;

    localparam int OPCODE_W = 4;
    localparam int MEMBER_W = 8;
    localparam int INDEX_W  = 4;
    localparam int WORD_W   = 16;
    localparam int KIND_W   = 3;

    localparam logic [OPCODE_W-1:0] OP_CLEAR_ALL    = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_MEMBER   = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_MEMBER = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_UNION_WORD   = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_SUB_WORD     = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_LOAD_MASK    = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_LOAD_WORD    = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_EMIT         = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_LIST_WORD    = 4'd8;

    localparam logic [KIND_W-1:0] KIND_ACK    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MASK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WORD   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MEMBER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 3'd4;

    // Highest word never holds member 256.
    localparam logic [INDEX_W-1:0] TOP_WORD   = 4'd15;
    localparam logic [WORD_W-1:0]  TOP_LEGAL  = 16'h7FFF;
    localparam logic [WORD_W-1:0]  FULL_WORD  = 16'hFFFF;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic accept;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic walk_needed;
        logic walk_final;
    } sts_t;

    function automatic logic [INDEX_W-1:0] lowest_bit(input logic [WORD_W-1:0] bits);
        logic [INDEX_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                pos = INDEX_W'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [WORD_W-1:0] legal_bits(input logic [INDEX_W-1:0] idx);
        return (idx == TOP_WORD) ? TOP_LEGAL : FULL_WORD;
    endfunction

endpackage

// File: rtl/sparse_bitset_engine.sv
// Top level of the sparse bitset engine: controller plus datapath.
// A result is registered at its transfer; list members come from the walker.
// Throughput: update opcodes take one item per cycle; emit gives the mask at
// transfer then one word per cycle, list gives one member per cycle after its
// transfer, both paced by the single result walker; all stall while m_ready is low.
// Reset: synchronous active-low aresetn empties the set and any pending load.
`timescale 1ns / 1ps

module sparse_bitset_engine #(
    parameter int WORD_COUNT = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbe_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [sbe_pkg::MEMBER_W-1:0]  s_member,
    input  logic [sbe_pkg::INDEX_W-1:0]   s_word_index,
    input  logic [sbe_pkg::WORD_W-1:0]    s_word_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbe_pkg::KIND_W-1:0]    m_kind,
    output logic [sbe_pkg::WORD_W-1:0]    m_value,
    output logic                          m_ok,
    output logic                          m_last
);

    sbe_pkg::cmd_t cmd;
    sbe_pkg::sts_t sts;

    sbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sbe_datapath #(
        .WORD_COUNT (WORD_COUNT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_opcode     (s_opcode),
        .s_member     (s_member),
        .s_word_index (s_word_index),
        .s_word_value (s_word_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_ok         (m_ok),
        .m_last       (m_last)
    );

endmodule

// File: rtl/sbe_ctrl.sv
// Controller state machine: input acceptance and result walk sequencing.
`timescale 1ns / 1ps

module sbe_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sbe_pkg::sts_t sts,
    output sbe_pkg::cmd_t cmd
);

    sbe_pkg::state_t state_reg;
    sbe_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            sbe_pkg::ST_IDLE: begin
                s_ready = sts.out_free;
                if (s_valid && sts.out_free) begin
                    cmd.accept = 1'b1;
                    if (sts.walk_needed) begin
                        state_next = sbe_pkg::ST_WALK;
                    end
                end
            end
            sbe_pkg::ST_WALK: begin
                if (sts.out_free) begin
                    cmd.step = 1'b1;
                    if (sts.walk_final) begin
                        state_next = sbe_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sbe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sbe_datapath.sv
// Datapath: set words, pending load mask, result walker and output register.
`timescale 1ns / 1ps

module sbe_datapath #(
    parameter int WORD_COUNT = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sbe_pkg::cmd_t                 cmd,
    output sbe_pkg::sts_t                 sts,
    input  logic [sbe_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [sbe_pkg::MEMBER_W-1:0]  s_member,
    input  logic [sbe_pkg::INDEX_W-1:0]   s_word_index,
    input  logic [sbe_pkg::WORD_W-1:0]    s_word_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbe_pkg::KIND_W-1:0]    m_kind,
    output logic [sbe_pkg::WORD_W-1:0]    m_value,
    output logic                          m_ok,
    output logic                          m_last
);

    localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam logic [sbe_pkg::WORD_W-1:0] WORDS_MASK =
        sbe_pkg::WORD_W'((17'd1 << WORD_COUNT) - 17'd1);
    localparam logic [sbe_pkg::MEMBER_W:0] MEMBER_MAX = 9'(WORD_COUNT * 16);
    localparam logic [sbe_pkg::INDEX_W:0]  INDEX_LIMIT = 5'(WORD_COUNT);

    logic [sbe_pkg::WORD_W-1:0]  set_words_reg [WORD_COUNT];
    logic [sbe_pkg::WORD_W-1:0]  set_words_next [WORD_COUNT];
    logic [sbe_pkg::WORD_W-1:0]  pending_reg, pending_next;
    logic [sbe_pkg::WORD_W-1:0]  walk_bits_reg, walk_bits_next;
    logic                        walk_list_reg, walk_list_next;
    logic [sbe_pkg::INDEX_W-1:0] walk_word_reg, walk_word_next;

    logic                        out_valid_reg, out_valid_next;
    logic [sbe_pkg::KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [sbe_pkg::WORD_W-1:0]  out_value_reg, out_value_next;
    logic                        out_ok_reg, out_ok_next;
    logic                        out_last_reg, out_last_next;

    logic [sbe_pkg::WORD_W-1:0]   words_nz;
    logic [sbe_pkg::MEMBER_W-1:0] member_m1;
    logic [sbe_pkg::INDEX_W-1:0]  mem_word;
    logic [sbe_pkg::INDEX_W-1:0]  mem_bit;
    logic                         member_bad;
    logic                         index_bad;
    logic [sbe_pkg::WORD_W-1:0]   idx_word;
    logic [sbe_pkg::INDEX_W-1:0]  load_pos;
    logic [sbe_pkg::INDEX_W-1:0]  walk_pos;
    logic [sbe_pkg::MEMBER_W:0]   walk_member;
    logic                         walk_needed;
    logic                         out_load;

    always_comb begin
        words_nz = '0;
        for (int i = 0; i < WORD_COUNT; i++) begin
            words_nz[i] = |set_words_reg[i];
        end
    end

    assign member_m1   = s_member - 8'd1;
    assign mem_word    = member_m1[7:4];
    assign mem_bit     = member_m1[3:0];
    assign member_bad  = (s_member == '0) || ({1'b0, s_member} > MEMBER_MAX);
    assign index_bad   = {1'b0, s_word_index} >= INDEX_LIMIT;
    assign idx_word    = set_words_reg[s_word_index[IDX_W-1:0]];
    assign load_pos    = sbe_pkg::lowest_bit(pending_reg);
    assign walk_pos    = sbe_pkg::lowest_bit(walk_bits_reg);
    assign walk_member = {1'b0, walk_word_reg, walk_pos} + 9'd1;

    assign walk_needed = ((s_opcode == sbe_pkg::OP_EMIT) && (words_nz != '0)) ||
                         ((s_opcode == sbe_pkg::OP_LIST_WORD) && !index_bad &&
                          (idx_word != '0));

    assign sts.out_free    = !out_valid_reg || m_ready;
    assign sts.walk_needed = walk_needed;
    assign sts.walk_final  = (walk_bits_reg & (walk_bits_reg - 16'd1)) == '0;

    always_comb begin
        set_words_next = set_words_reg;
        pending_next   = pending_reg;
        walk_bits_next = walk_bits_reg;
        walk_list_next = walk_list_reg;
        walk_word_next = walk_word_reg;
        out_kind_next  = out_kind_reg;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        out_load       = 1'b0;

        if (cmd.accept) begin
            out_load       = 1'b1;
            out_kind_next  = sbe_pkg::KIND_ACK;
            out_value_next = '0;
            out_ok_next    = 1'b1;
            out_last_next  = 1'b1;
            unique case (s_opcode) inside
                sbe_pkg::OP_CLEAR_ALL: begin
                    for (int i = 0; i < WORD_COUNT; i++) begin
                        set_words_next[i] = '0;
                    end
                    pending_next = '0;
                end
                sbe_pkg::OP_SET_MEMBER, sbe_pkg::OP_CLEAR_MEMBER: begin
                    if (member_bad) begin
                        out_ok_next = 1'b0;
                    end else if (s_opcode == sbe_pkg::OP_SET_MEMBER) begin
                        set_words_next[mem_word[IDX_W-1:0]][mem_bit] = 1'b1;
                    end else begin
                        set_words_next[mem_word[IDX_W-1:0]][mem_bit] = 1'b0;
                    end
                end
                sbe_pkg::OP_UNION_WORD, sbe_pkg::OP_SUB_WORD: begin
                    if (index_bad) begin
                        out_ok_next = 1'b0;
                    end else if (s_opcode == sbe_pkg::OP_UNION_WORD) begin
                        set_words_next[s_word_index[IDX_W-1:0]] =
                            (idx_word | s_word_value) & sbe_pkg::legal_bits(s_word_index);
                    end else begin
                        set_words_next[s_word_index[IDX_W-1:0]] = idx_word & ~s_word_value;
                    end
                end
                sbe_pkg::OP_LOAD_MASK: begin
                    if ((s_word_value & ~WORDS_MASK) != '0) begin
                        out_ok_next = 1'b0;
                    end else begin
                        for (int i = 0; i < WORD_COUNT; i++) begin
                            set_words_next[i] = '0;
                        end
                        pending_next = s_word_value;
                    end
                end
                sbe_pkg::OP_LOAD_WORD: begin
                    if (pending_reg == '0) begin
                        out_ok_next = 1'b0;
                    end else begin
                        set_words_next[load_pos[IDX_W-1:0]] =
                            s_word_value & sbe_pkg::legal_bits(load_pos);
                        pending_next[load_pos] = 1'b0;
                        out_value_next = {12'd0, load_pos};
                    end
                end
                sbe_pkg::OP_EMIT: begin
                    out_kind_next  = sbe_pkg::KIND_MASK;
                    out_value_next = words_nz;
                    out_last_next  = (words_nz == '0);
                    walk_bits_next = words_nz;
                    walk_list_next = 1'b0;
                end
                sbe_pkg::OP_LIST_WORD: begin
                    if (index_bad) begin
                        out_ok_next = 1'b0;
                    end else if (idx_word == '0) begin
                        out_kind_next = sbe_pkg::KIND_EMPTY;
                    end else begin
                        out_load       = 1'b0;
                        walk_bits_next = idx_word;
                        walk_list_next = 1'b1;
                        walk_word_next = s_word_index;
                    end
                end
                default: begin
                    out_ok_next = 1'b0;
                end
            endcase
        end else if (cmd.step) begin
            out_load                 = 1'b1;
            out_ok_next              = 1'b1;
            out_last_next            = sts.walk_final;
            walk_bits_next[walk_pos] = 1'b0;
            if (walk_list_reg) begin
                out_kind_next  = sbe_pkg::KIND_MEMBER;
                out_value_next = {7'd0, walk_member};
            end else begin
                out_kind_next  = sbe_pkg::KIND_WORD;
                out_value_next = set_words_reg[walk_pos[IDX_W-1:0]];
            end
        end

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORD_COUNT; i++) begin
                set_words_reg[i] <= '0;
            end
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            set_words_reg <= set_words_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_bits_reg <= walk_bits_next;
        walk_list_reg <= walk_list_next;
        walk_word_reg <= walk_word_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid = out_valid_reg;
    assign m_kind  = out_kind_reg;
    assign m_value = out_value_reg;
    assign m_ok    = out_ok_reg;
    assign m_last  = out_last_reg;

endmodule

// File: tb/sparse_bitset_engine_test.sv
// Self-checking testbench for the sparse bitset engine: directed and random opcode streams.
`timescale 1ns / 1ps

module sparse_bitset_engine_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 225;

    typedef struct packed {
        logic [sbe_pkg::KIND_W-1:0] kind;
        logic [sbe_pkg::WORD_W-1:0] value;
        logic                       ok;
        logic                       last;
    } result_t;

    class bitset_scoreboard;
        logic [sbe_pkg::WORD_W-1:0] words [16];
        logic [sbe_pkg::WORD_W-1:0] load_pending;
        result_t                    expected_q [$];
        int                         mismatches;

        function new();
            foreach (words[i]) words[i] = '0;
            load_pending = '0;
            mismatches = 0;
        endfunction

        function void push(logic [sbe_pkg::KIND_W-1:0] kind,
                           logic [sbe_pkg::WORD_W-1:0] value, logic ok, logic last);
            result_t r;
            r.kind = kind;
            r.value = value;
            r.ok = ok;
            r.last = last;
            expected_q.push_back(r);
        endfunction

        function void note_input(logic [sbe_pkg::OPCODE_W-1:0] op,
                                 logic [sbe_pkg::MEMBER_W-1:0] mbr,
                                 logic [sbe_pkg::INDEX_W-1:0] idx,
                                 logic [sbe_pkg::WORD_W-1:0] val);
            logic [sbe_pkg::MEMBER_W-1:0] slot;
            logic [sbe_pkg::WORD_W-1:0]   mask;
            logic [sbe_pkg::WORD_W-1:0]   keep;
            int                           w;
            case (op)
                sbe_pkg::OP_CLEAR_ALL: begin
                    foreach (words[i]) words[i] = '0;
                    load_pending = '0;
                    push(sbe_pkg::KIND_ACK, '0, 1'b1, 1'b1);
                end
                sbe_pkg::OP_SET_MEMBER, sbe_pkg::OP_CLEAR_MEMBER: begin
                    if (mbr == '0) begin
                        push(sbe_pkg::KIND_ACK, '0, 1'b0, 1'b1);
                    end else begin
                        slot = mbr - 8'd1;
                        if (op == sbe_pkg::OP_SET_MEMBER)
                            words[slot[7:4]][slot[3:0]] = 1'b1;
                        else
                            words[slot[7:4]][slot[3:0]] = 1'b0;
                        push(sbe_pkg::KIND_ACK, '0, 1'b1, 1'b1);
                    end
                end
                sbe_pkg::OP_UNION_WORD: begin
                    keep = (idx == sbe_pkg::TOP_WORD) ? sbe_pkg::TOP_LEGAL : sbe_pkg::FULL_WORD;
                    words[idx] = (words[idx] | val) & keep;
                    push(sbe_pkg::KIND_ACK, '0, 1'b1, 1'b1);
                end
                sbe_pkg::OP_SUB_WORD: begin
                    words[idx] = words[idx] & ~val;
                    push(sbe_pkg::KIND_ACK, '0, 1'b1, 1'b1);
                end
                sbe_pkg::OP_LOAD_MASK: begin
                    foreach (words[i]) words[i] = '0;
                    load_pending = val;
                    push(sbe_pkg::KIND_ACK, '0, 1'b1, 1'b1);
                end
                sbe_pkg::OP_LOAD_WORD: begin
                    if (load_pending == '0) begin
                        push(sbe_pkg::KIND_ACK, '0, 1'b0, 1'b1);
                    end else begin
                        w = 0;
                        while (!load_pending[w]) w++;
                        keep = (w == 15) ? sbe_pkg::TOP_LEGAL : sbe_pkg::FULL_WORD;
                        words[w] = val & keep;
                        load_pending[w] = 1'b0;
                        push(sbe_pkg::KIND_ACK, sbe_pkg::WORD_W'(w), 1'b1, 1'b1);
                    end
                end
                sbe_pkg::OP_EMIT: begin
                    mask = '0;
                    for (int i = 0; i < 16; i++) mask[i] = (words[i] != '0);
                    push(sbe_pkg::KIND_MASK, mask, 1'b1, mask == '0);
                    for (int i = 0; i < 16; i++)
                        if (mask[i])
                            push(sbe_pkg::KIND_WORD, words[i], 1'b1,
                                 (32'(mask) >> (i + 1)) == 0);
                end
                sbe_pkg::OP_LIST_WORD: begin
                    keep = words[idx];
                    if (keep == '0) begin
                        push(sbe_pkg::KIND_EMPTY, '0, 1'b1, 1'b1);
                    end else begin
                        for (int b = 0; b < 16; b++)
                            if (keep[b])
                                push(sbe_pkg::KIND_MEMBER,
                                     sbe_pkg::WORD_W'(int'(idx) * 16 + b + 1), 1'b1,
                                     (32'(keep) >> (b + 1)) == 0);
                    end
                end
                default: push(sbe_pkg::KIND_ACK, '0, 1'b0, 1'b1);
            endcase
        endfunction

        function void check_result(logic [sbe_pkg::KIND_W-1:0] kind,
                                   logic [sbe_pkg::WORD_W-1:0] value, logic ok, logic last);
            result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d value %h ok %b last %b",
                             kind, value, ok, last);
                return;
            end
            want = expected_q.pop_front();
            if (want.kind !== kind || want.value !== value || want.ok !== ok ||
                want.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d %h %b %b, actual %0d %h %b %b",
                             want.kind, want.value, want.ok, want.last,
                             kind, value, ok, last);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [sbe_pkg::OPCODE_W-1:0]  s_opcode = '0;
    logic [sbe_pkg::MEMBER_W-1:0]  s_member = '0;
    logic [sbe_pkg::INDEX_W-1:0]   s_word_index = '0;
    logic [sbe_pkg::WORD_W-1:0]    s_word_value = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [sbe_pkg::KIND_W-1:0]    m_kind;
    logic [sbe_pkg::WORD_W-1:0]    m_value;
    logic                          m_ok;
    logic                          m_last;

    bitset_scoreboard board = new();
    int send_idle_pct = 23;
    int recv_idle_pct = 77;
    int items_sent = 0;
    int quiet_cycles = 0;

    sparse_bitset_engine dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_member     (s_member),
        .s_word_index (s_word_index),
        .s_word_value (s_word_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_value      (m_value),
        .m_ok         (m_ok),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_kind, m_value, m_ok, m_last);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sparse_bitset_engine_test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [sbe_pkg::OPCODE_W-1:0] op,
                             input logic [sbe_pkg::MEMBER_W-1:0] mbr,
                             input logic [sbe_pkg::INDEX_W-1:0] idx,
                             input logic [sbe_pkg::WORD_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_member <= mbr;
        s_word_index <= idx;
        s_word_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(op, mbr, idx, val);
        items_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic send_random_update();
        logic [sbe_pkg::MEMBER_W-1:0] mbr;
        mbr = ($urandom_range(15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        send_item(sbe_pkg::OPCODE_W'($urandom_range(1, 4)), mbr, 4'($urandom),
                  16'($urandom));
    endtask

    task automatic random_items(input int count);
        int stop_at;
        int pick;
        int words_left;
        logic [sbe_pkg::WORD_W-1:0] mask;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
                send_item(sbe_pkg::OP_LOAD_MASK, 8'($urandom), 4'($urandom), mask);
                words_left = $countones(mask);
                case ($urandom_range(5))
                    0: words_left = words_left + 1;
                    1: words_left = $urandom_range(words_left);
                    default: ;
                endcase
                repeat (words_left) begin
                    if ($urandom_range(7) == 0)
                        send_random_update();
                    send_item(sbe_pkg::OP_LOAD_WORD, 8'($urandom), 4'($urandom),
                              16'($urandom));
                end
            end else if (pick < 18) begin
                send_item(sbe_pkg::OP_CLEAR_ALL, 8'($urandom), 4'($urandom), 16'($urandom));
            end else if (pick < 23) begin
                send_item(sbe_pkg::OPCODE_W'($urandom_range(9, 15)), 8'($urandom),
                          4'($urandom), 16'($urandom));
            end else if (pick < 35) begin
                send_item(sbe_pkg::OP_EMIT, 8'($urandom), 4'($urandom), 16'($urandom));
            end else if (pick < 47) begin
                send_item(sbe_pkg::OP_LIST_WORD, 8'($urandom), 4'($urandom), 16'($urandom));
            end else begin
                send_random_update();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: boundaries, rejects, load sequencing
        send_item(sbe_pkg::OP_LOAD_WORD, 8'd0, 4'd0, 16'h1234);
        send_item(sbe_pkg::OP_CLEAR_ALL, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_SET_MEMBER, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_SET_MEMBER, 8'd1, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_SET_MEMBER, 8'd255, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_SET_MEMBER, 8'd16, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_EMIT, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_LIST_WORD, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_CLEAR_MEMBER, 8'd2, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_CLEAR_MEMBER, 8'd1, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_UNION_WORD, 8'd0, 4'd15, 16'hFFFF);
        send_item(sbe_pkg::OP_LIST_WORD, 8'd0, 4'd15, 16'h0000);
        send_item(sbe_pkg::OP_SUB_WORD, 8'd0, 4'd15, 16'h0F0F);
        send_item(sbe_pkg::OP_LIST_WORD, 8'd0, 4'd7, 16'h0000);
        send_item(sbe_pkg::OP_LOAD_MASK, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_EMIT, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_LOAD_MASK, 8'd0, 4'd0, 16'h8001);
        send_item(sbe_pkg::OP_LOAD_WORD, 8'd0, 4'd0, 16'hFFFF);
        send_item(sbe_pkg::OP_SET_MEMBER, 8'd40, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_LOAD_WORD, 8'd0, 4'd0, 16'hFFFF);
        send_item(sbe_pkg::OP_LOAD_WORD, 8'd0, 4'd0, 16'h0001);
        send_item(sbe_pkg::OP_EMIT, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_LOAD_MASK, 8'd0, 4'd0, 16'hFFFF);
        send_item(sbe_pkg::OP_CLEAR_ALL, 8'd0, 4'd0, 16'h0000);
        send_item(sbe_pkg::OP_LOAD_WORD, 8'd0, 4'd0, 16'h0000);
        send_item(4'd15, 8'd0, 4'd0, 16'h0000);
        drain_results();

        random_items(RANDOM_ITEMS / 3);
        drain_results();

        send_idle_pct = 77;
        recv_idle_pct = 23;
        random_items(RANDOM_ITEMS / 3);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_items(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_results();
        repeat (10) @(posedge aclk);

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("sparse_bitset_engine_test passed");
        else
            $display("sparse_bitset_engine_test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/sbe_pkg.sv
rtl/sbe_ctrl.sv
rtl/sbe_datapath.sv
rtl/sparse_bitset_engine.sv
tb/sparse_bitset_engine_test.sv
